### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RTL file that carries checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is high.
`define SLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define SLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Types, codes and key ordering helpers for the sorted list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  localparam int DEPTH_DEFAULT = 64;

  // Request function codes
  localparam logic [2:0] FUNC_INSERT    = 3'd0;
  localparam logic [2:0] FUNC_APPEND    = 3'd1;
  localparam logic [2:0] FUNC_DELETE    = 3'd2;
  localparam logic [2:0] FUNC_READ      = 3'd3;
  localparam logic [2:0] FUNC_OVERWRITE = 3'd4;

  // Response status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    KIND_INT32 = 2'd0,
    KIND_FLT32 = 2'd1,
    KIND_CHAR  = 2'd2,
    KIND_FLT64 = 2'd3
  } kind_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] key;
    logic [6:0]  position;
  } req_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic [6:0]  count;
  } rsp_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    COP_NONE,
    COP_CMP,
    COP_INS,
    COP_DELETE,
    COP_WRITE,
    COP_RDLOAD,
    COP_RDSHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [63:0] key;   // masked key to store
    logic [63:0] okey;  // order-mapped key for compares
  } cell_cmd_t;

  // Bits of the key that the kind keeps
  function automatic logic [63:0] kind_mask(input kind_t kind);
    logic [63:0] m;
    case (kind)
      KIND_INT32: m = 64'h0000_0000_FFFF_FFFF;
      KIND_FLT32: m = 64'h0000_0000_FFFF_FFFF;
      KIND_CHAR:  m = 64'h0000_0000_0000_00FF;
      default:    m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  // Map key bits to an unsigned word with the same order
  function automatic logic [63:0] order_key(input logic [63:0] raw, input kind_t kind);
    logic [31:0] b32;
    logic [63:0] b64;
    logic [63:0] r;
    b32 = raw[31:0];
    b64 = raw;
    // minus zero folds onto plus zero
    if (b32[30:0] == 31'd0) b32 = 32'd0;
    if (b64[62:0] == 63'd0) b64 = 64'd0;
    case (kind)
      KIND_INT32: r = {32'd0, raw[31:0] ^ 32'h8000_0000};
      KIND_FLT32: r = {32'd0, b32[31] ? ~b32 : (b32 | 32'h8000_0000)};
      KIND_CHAR:  r = {56'd0, raw[7:0] ^ 8'h80};
      default:    r = b64[63] ? ~b64 : (b64 | 64'h8000_0000_0000_0000);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell
// One list slot: holds an entry, compares it with the request key, and
// trades entries and read data with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 6,
  parameter int OCC_W = 7
) (
  input  logic              clk,
  input  sle_pkg::cell_cmd_t cmd,
  input  sle_pkg::kind_t    kind,
  input  logic [OCC_W-1:0]  occ,
  input  logic [IDX_W-1:0]  pidx,
  input  logic              ge_left,
  input  logic              ge_self,
  input  logic [63:0]       left_entry,
  input  logic [63:0]       right_entry,
  input  logic [63:0]       rd_in,
  output logic [63:0]       entry,
  output logic [63:0]       rd,
  output logic              stop
);
  import sle_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(INDEX);
  localparam logic [OCC_W-1:0] MY_OCC  = OCC_W'(INDEX);
  localparam logic [OCC_W-1:0] MY_NEXT = OCC_W'(INDEX + 1);
  localparam bit               IS_HEAD = (INDEX == 0);

  logic        lt;
  logic        gt;
  logic [63:0] ent_ord;

  assign ent_ord = order_key(entry, kind);

  // Insert point: the head stops when greater, later cells when not smaller;
  // the slot right after the tail always stops.
  assign stop = (IS_HEAD ? gt : (!lt && (MY_OCC < occ))) || (MY_OCC == occ);

  // Slot update
  always_ff @(posedge clk) begin
    case (cmd.op)
      COP_CMP: begin
        lt <= (ent_ord < cmd.okey);
        gt <= (ent_ord > cmd.okey);
      end
      COP_INS: begin
        if (ge_left) begin
          entry <= left_entry;
        end else if (ge_self) begin
          entry <= cmd.key;
        end
      end
      COP_DELETE: begin
        if ((MY_IDX >= pidx) && (MY_NEXT < occ)) begin
          entry <= right_entry;
        end
      end
      COP_WRITE: begin
        if (MY_IDX == pidx) begin
          entry <= cmd.key;
        end
      end
      COP_RDLOAD:  rd <= entry;
      COP_RDSHIFT: rd <= rd_in;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/sle_scan.sv
// ----------------------------------------------------------------------------
// sle_scan
// Inclusive prefix OR over the cell stop flags; marks every slot at or past
// the insert point.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_scan #(
  parameter int DEPTH = 64
) (
  input  logic [DEPTH-1:0] stop,
  output logic [DEPTH-1:0] ge
);

  localparam int LEVELS = $clog2(DEPTH);

  logic [DEPTH-1:0] lvl [LEVELS+1];

  // Log-depth prefix network
  always_comb begin
    lvl[0] = stop;
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i >= (1 << l)) begin
          lvl[l+1][i] = lvl[l][i] | lvl[l][i - (1 << l)];
        end else begin
          lvl[l+1][i] = lvl[l][i];
        end
      end
    end
  end

  assign ge = lvl[LEVELS];

endmodule

`default_nettype wire

### rtl/sorted_list_engine_top.sv
// ----------------------------------------------------------------------------
// sorted_list_engine_top: bounded sorted list on a chain of slot cells.
// Request path: idle, execute, insert (stored insert) or read (good read), done.
// A new request is taken only in idle; a response that waits holds the done state.
// Sync reset empties the list and sets key kind int32; entries are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sorted_list_engine_top #(
  parameter int DEPTH = sle_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sle_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_ready,
  output sle_pkg::rsp_t out_rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_data
);
  import sle_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CW    = (OCC_W > 7) ? OCC_W : 7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INS,
    S_READ,
    S_DONE
  } state_t;

  state_t           state;
  kind_t            key_kind;
  logic [2:0]       func_r;
  logic [63:0]      key_r;
  logic [63:0]      okey_r;
  logic [6:0]       pos_r;
  logic [OCC_W-1:0] occ;
  logic [IDX_W-1:0] cnt;
  logic [63:0]      res_value;
  logic [1:0]       res_status;

  logic             full;
  logic             pos_ok;
  logic [IDX_W-1:0] pidx;
  logic [63:0]      key_in_m;
  cell_cmd_t        cmd;

  logic [63:0]      ent   [DEPTH];
  logic [63:0]      rdb   [DEPTH];
  logic [DEPTH-1:0] stop;
  logic [DEPTH-1:0] ge;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // Key kind register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_kind <= KIND_INT32;
    end else if (cfg_valid) begin
      key_kind <= kind_t'(cfg_data);
    end
  end

  // Request decode
  assign key_in_m = in_req.key & kind_mask(key_kind);
  assign full     = (occ >= OCC_W'(DEPTH));
  assign pos_ok   = (pos_r != 7'd0) && (CW'(pos_r) <= CW'(occ));
  assign pidx     = (func_r == FUNC_APPEND) ? IDX_W'(occ) : IDX_W'(7'(pos_r - 7'd1));

  // Broadcast command to the chain
  always_comb begin
    cmd.key  = key_r;
    cmd.okey = okey_r;
    cmd.op   = COP_NONE;
    case (state)
      S_EXEC: begin
        case (func_r)
          FUNC_INSERT:    cmd.op = full ? COP_NONE : COP_CMP;
          FUNC_APPEND:    cmd.op = full ? COP_NONE : COP_WRITE;
          FUNC_DELETE:    cmd.op = pos_ok ? COP_DELETE : COP_NONE;
          FUNC_READ:      cmd.op = pos_ok ? COP_RDLOAD : COP_NONE;
          FUNC_OVERWRITE: cmd.op = pos_ok ? COP_WRITE : COP_NONE;
          default:        cmd.op = COP_NONE;
        endcase
      end
      S_INS:   cmd.op = COP_INS;
      S_READ:  cmd.op = (cnt != '0) ? COP_RDSHIFT : COP_NONE;
      default: cmd.op = COP_NONE;
    endcase
  end

  // Control sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      // done state owns out_valid in its own cycle
      if (out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_r <= in_req.func;
            key_r  <= key_in_m;
            okey_r <= order_key(key_in_m, key_kind);
            pos_r  <= in_req.position;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_value <= '0;
          case (func_r)
            FUNC_INSERT: begin
              if (full) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                state      <= S_INS;
              end
            end
            FUNC_APPEND: begin
              state <= S_DONE;
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_OK;
                occ        <= occ + OCC_W'(1);
              end
            end
            FUNC_DELETE: begin
              state <= S_DONE;
              if (!pos_ok) begin
                res_status <= ST_RANGE;
              end else begin
                res_status <= ST_OK;
                occ        <= occ - OCC_W'(1);
              end
            end
            FUNC_READ: begin
              if (!pos_ok) begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                cnt        <= pidx;
                state      <= S_READ;
              end
            end
            FUNC_OVERWRITE: begin
              state      <= S_DONE;
              res_status <= pos_ok ? ST_OK : ST_RANGE;
            end
            default: begin
              state      <= S_DONE;
              res_status <= ST_OK;
            end
          endcase
        end
        S_INS: begin
          occ   <= occ + OCC_W'(1);
          state <= S_DONE;
        end
        S_READ: begin
          if (cnt == '0) begin
            res_value <= rdb[0];
            state     <= S_DONE;
          end else begin
            cnt <= cnt - IDX_W'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_rsp.value  <= res_value;
            out_rsp.status <= res_status;
            out_rsp.count  <= 7'(occ);
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Insert point scan
  sle_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .stop (stop),
    .ge   (ge)
  );

  // Cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [63:0] lft;
    logic [63:0] rgt;
    logic [63:0] rdi;
    logic        gel;

    if (g == 0) begin : g_head
      assign lft = '0;
      assign gel = 1'b0;
    end else begin : g_body
      assign lft = ent[g-1];
      assign gel = ge[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign rgt = '0;
      assign rdi = '0;
    end else begin : g_mid
      assign rgt = ent[g+1];
      assign rdi = rdb[g+1];
    end

    sle_cell #(
      .INDEX (g),
      .IDX_W (IDX_W),
      .OCC_W (OCC_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .kind        (key_kind),
      .occ         (occ),
      .pidx        (pidx),
      .ge_left     (gel),
      .ge_self     (ge[g]),
      .left_entry  (lft),
      .right_entry (rgt),
      .rd_in       (rdi),
      .entry       (ent[g]),
      .rd          (rdb[g]),
      .stop        (stop[g])
    );
  end

  // Checks
  `SLE_ASSERT(a_insert_grows,
    (in_valid && in_ready && (in_req.func == FUNC_INSERT) && (occ < OCC_W'(DEPTH)))
      |-> ##3 (occ == $past(occ, 3) + OCC_W'(1)),
    "insert did not grow the list")
  `SLE_ASSERT(a_delete_shrinks,
    (in_valid && in_ready && (in_req.func == FUNC_DELETE) && (in_req.position != 7'd0)
      && (CW'(in_req.position) <= CW'(occ))) |-> ##2 (occ == $past(occ, 2) - OCC_W'(1)),
    "delete did not shrink the list")
  `SLE_ASSERT(a_rsp_from_done, $rose(out_valid) |-> ($past(state) == S_DONE),
    "response loaded outside done state")
  `SLE_ASSERT_ALWAYS(a_occ_bound, (rst || (occ <= OCC_W'(DEPTH))), "occupancy above depth")

endmodule

`default_nettype wire
